@@ rtl/bdq_pkg.sv @@
// bdq_pkg: sizes, codes, shared types and the slot helper of the bounded deque
// depends on nothing; imported by every other file of the block

package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [2:0]        opcode_t;
    typedef logic [1:0]        status_t;

    localparam opcode_t OP_PUSH_FRONT = 3'd0;
    localparam opcode_t OP_PUSH_BACK  = 3'd1;
    localparam opcode_t OP_REMOVE     = 3'd2;
    localparam opcode_t OP_DUMP_FWD   = 3'd3;
    localparam opcode_t OP_DUMP_REV   = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

    // memory access request from the sequencer
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        data_t wr_data;
    } bdq_mem_req_t;

    // one result item
    typedef struct packed {
        status_t status;
        data_t   element;
        cnt_t    count;
        logic    last;
    } bdq_res_t;

    // physical slot of a logical position, head plus position wrapped once
    function automatic idx_t bdq_slot(idx_t head, cnt_t pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return idx_t'(sum);
    endfunction

endpackage

@@ rtl/bdq_req_if.sv @@
// bdq_req_if: request channel of the bounded deque, valid/ready plus payload
// depends on bdq_pkg

interface bdq_req_if
    import bdq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

@@ rtl/bdq_rsp_if.sv @@
// bdq_rsp_if: result channel of the bounded deque, valid/ready plus payload
// depends on bdq_pkg

interface bdq_rsp_if
    import bdq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [CNT_W-1:0]   count;
    logic               last_of_run;

    modport source (output valid, output status, output element, output count,
                    output last_of_run, input ready);
    modport sink   (input valid, input status, input element, input count,
                    input last_of_run, output ready);
endinterface

@@ rtl/bdq_store.sv @@
// bdq_store: entry memory, one write and one registered read port
// depends on bdq_pkg

module bdq_store
    import bdq_pkg::*;
(
    input  logic         clk,
    input  bdq_mem_req_t mem_req,
    output data_t        rd_data
);

    data_t mem [DEPTH];
    data_t rd_data_reg;

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bdq_out_stage.sv @@
// bdq_out_stage: result register between the sequencer and the result channel
// depends on bdq_pkg and bdq_rsp_if

module bdq_out_stage
    import bdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  bdq_res_t         res,
    output logic             free,
    bdq_rsp_if.source        rsp
);

    logic     valid_reg;
    bdq_res_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.status      = data_reg.status;
    assign rsp.element     = $signed(data_reg.element);
    assign rsp.count       = data_reg.count;
    assign rsp.last_of_run = data_reg.last;

endmodule

@@ rtl/bdq_ctrl.sv @@
// bdq_ctrl: sequencer of the bounded deque, holds head and count and
// walks the entry memory for search, shift and dump; depends on bdq_pkg

module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bdq_req_if.sink      req,
    input  data_t        rd_data,
    output bdq_mem_req_t mem_req,
    input  logic         out_free,
    output logic         res_valid,
    output bdq_res_t     res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_SHIFT,
        S_DUMP,
        S_RESP
    } state_t;

    state_t  state_reg, state_next;
    opcode_t op_reg, op_next;
    data_t   val_reg, val_next;
    idx_t    head_reg, head_next;
    cnt_t    count_reg, count_next;
    cnt_t    iss_pos_reg, iss_pos_next;
    logic    rd_pend_reg, rd_pend_next;
    cnt_t    rd_pos_reg, rd_pos_next;
    status_t st_reg, st_next;

    logic full;
    idx_t head_dec;
    logic more;
    logic issue;
    logic emit;
    cnt_t dump_pos;

    assign full     = (count_reg == cnt_t'(DEPTH));
    assign head_dec = (head_reg == '0) ? idx_t'(DEPTH - 1) : head_reg - idx_t'(1);
    assign more     = (iss_pos_reg < count_reg);
    assign dump_pos = (op_reg == OP_DUMP_FWD) ? iss_pos_reg
                                              : count_reg - cnt_t'(1) - iss_pos_reg;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        iss_pos_next = iss_pos_reg;
        rd_pend_next = rd_pend_reg;
        rd_pos_next  = rd_pos_reg;
        st_next      = st_reg;
        mem_req      = '0;
        res_valid    = 1'b0;
        res          = '0;
        issue        = 1'b0;
        emit         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    val_next   = data_t'(req.value);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                iss_pos_next = '0;
                rd_pend_next = 1'b0;
                case (op_reg) inside
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        state_next = S_RESP;
                        if (full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_data = val_reg;
                            if (op_reg == OP_PUSH_FRONT)
                            begin
                                mem_req.wr_addr = head_dec;
                                head_next       = head_dec;
                            end
                            else
                            begin
                                mem_req.wr_addr = bdq_slot(head_reg, count_reg);
                            end
                            count_next = count_reg + cnt_t'(1);
                            st_next    = ST_OK;
                        end
                    end
                    OP_REMOVE:
                    begin
                        state_next = S_SEARCH;
                    end
                    OP_DUMP_FWD, OP_DUMP_REV:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SEARCH:
            begin
                // compare the entry read last cycle while the next one is fetched
                if (rd_pend_reg && (rd_data == val_reg))
                begin
                    iss_pos_next = rd_pos_reg + cnt_t'(1);
                    rd_pend_next = 1'b0;
                    state_next   = S_SHIFT;
                end
                else if (!rd_pend_reg && !more)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else
                begin
                    issue = more;
                end
            end

            S_SHIFT:
            begin
                // entry at position p moves down to p - 1
                if (rd_pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = bdq_slot(head_reg, rd_pos_reg - cnt_t'(1));
                    mem_req.wr_data = rd_data;
                end
                if (!rd_pend_reg && !more)
                begin
                    count_next = count_reg - cnt_t'(1);
                    if (count_reg == cnt_t'(1))
                    begin
                        head_next = '0;
                    end
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    issue = more;
                end
            end

            S_DUMP:
            begin
                emit = rd_pend_reg && out_free;
                if (emit)
                begin
                    res_valid   = 1'b1;
                    res.status  = ST_OK;
                    res.element = rd_data;
                    res.count   = count_reg;
                    res.last    = (rd_pos_reg == count_reg - cnt_t'(1));
                end
                if (!rd_pend_reg && !more)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    // fetch ahead when no entry is held or the held entry leaves this cycle
                    issue = more && (!rd_pend_reg || out_free);
                    if (!issue && emit)
                    begin
                        rd_pend_next = 1'b0;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    res.status = st_reg;
                    res.count  = count_reg;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_SEARCH || state_reg == S_SHIFT || state_reg == S_DUMP)
        begin
            if (issue)
            begin
                mem_req.rd_en = 1'b1;
                mem_req.rd_addr = bdq_slot(head_reg,
                                           (state_reg == S_DUMP) ? dump_pos : iss_pos_reg);
                rd_pend_next  = 1'b1;
                rd_pos_next   = iss_pos_reg;
                iss_pos_next  = iss_pos_reg + cnt_t'(1);
            end
            else if (state_reg != S_DUMP && state_next == state_reg)
            begin
                rd_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_PUSH_FRONT;
            val_reg     <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            iss_pos_reg <= '0;
            rd_pend_reg <= 1'b0;
            rd_pos_reg  <= '0;
            st_reg      <= ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            val_reg     <= val_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            iss_pos_reg <= iss_pos_next;
            rd_pend_reg <= rd_pend_next;
            rd_pos_reg  <= rd_pos_next;
            st_reg      <= st_next;
        end
    end

endmodule

@@ rtl/bounded_deque_with_value_removal_unit.sv @@
// bounded_deque_with_value_removal_unit: top level of the bounded deque
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_store, bdq_ctrl, bdq_out_stage
//
// Usage:
//   req carries opcode and value; one request is taken per transfer, and only
//   while the sequencer is idle. rsp carries status, element, count and
//   last_of_run; last_of_run marks the final result of a request.
//   Push: one result, from S_EXEC through S_RESP into the output register.
//   Remove: the search reads one entry per cycle from the entry memory, and
//   the shift moves one entry per cycle.
//   Dump: one result per entry (one ST_EMPTY result when the deque is empty),
//   one per cycle while rsp is ready, paced by the single memory read port.
//   Unused opcodes are dropped in S_EXEC with no result.
//   A new request is taken only once the sequencer is back in S_IDLE, after
//   the previous result has entered the output register.
//   Reset clears head and count; the entry memory is left as is and needs
//   no clearing pass, since only live entries are read.
//   When rsp stalls, the output register holds its result and the sequencer
//   waits; nothing is dropped or repeated.

module bounded_deque_with_value_removal_unit
    import bdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    bdq_mem_req_t mem_req;
    data_t        rd_data;
    logic         out_free;
    logic         res_valid;
    bdq_res_t     res;

    bdq_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rd_data   (rd_data),
        .mem_req   (mem_req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    bdq_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .rsp       (rsp)
    );

endmodule

@@ tb/sv/bdq_deque_checker.sv @@
`timescale 1ns / 100ps
// bdq_deque_checker: watches both channels of the bounded deque, keeps its own
// copy of the store, predicts each result and compares it field by field
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if

module bdq_deque_checker
    import bdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bdq_req_if   req,
    bdq_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   checked,
    output int   refused_full,
    output int   remove_misses,
    output int   empty_dumps
);

    data_t    entries [DEPTH];
    idx_t     head;
    cnt_t     fill;
    bdq_res_t expected_q [$];

    int fails = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_miss = 0;
    int n_empty = 0;

    function automatic idx_t slot_of(input int pos);
        return idx_t'((int'(head) + pos) % DEPTH);
    endfunction

    function automatic void expect_result(input status_t st, input data_t elem, input logic last);
        bdq_res_t r;
        r.status  = st;
        r.element = elem;
        r.count   = fill;
        r.last    = last;
        expected_q.push_back(r);
    endfunction

    function automatic void apply_request(input opcode_t op, input data_t val);
        int hit;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill >= DEPTH) begin
                    expect_result(ST_FULL, '0, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        head = (head == '0) ? idx_t'(DEPTH - 1) : head - idx_t'(1);
                        entries[head] = val;
                    end else begin
                        entries[slot_of(fill)] = val;
                    end
                    fill = fill + cnt_t'(1);
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            OP_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < fill; i++) begin
                    if (hit < 0 && entries[slot_of(i)] == val) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    expect_result(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    // close the gap toward the front
                    for (int j = hit; j + 1 < fill; j++) begin
                        entries[slot_of(j)] = entries[slot_of(j + 1)];
                    end
                    fill = fill - cnt_t'(1);
                    if (fill == '0) begin
                        head = '0;
                    end
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            OP_DUMP_FWD, OP_DUMP_REV:
            begin
                if (fill == '0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < fill; i++) begin
                        expect_result(ST_OK,
                            entries[slot_of((op == OP_DUMP_FWD) ? i : int'(fill) - 1 - i)],
                            (i + 1 == fill));
                    end
                end
            end
            default:
            begin
                // unused opcodes are dropped without a result
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head = '0;
            fill = '0;
            expected_q.delete();
            fail_count    <= 0;
            pending       <= 0;
            checked       <= 0;
            refused_full  <= 0;
            remove_misses <= 0;
            empty_dumps   <= 0;
        end else begin
            // results first: a result always belongs to an earlier request
            if (rsp.valid && rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual status %0d",
                             $time, rsp.status);
                    $display("    element %0h count %0d last %0b",
                             rsp.element, rsp.count, rsp.last_of_run);
                    fails++;
                end else begin
                    bdq_res_t e;
                    e = expected_q.pop_front();
                    check_field("status", 32'(e.status), 32'(rsp.status));
                    check_field("element", e.element, rsp.element);
                    check_field("count", 32'(e.count), 32'(rsp.count));
                    check_field("last_of_run", 32'(e.last), 32'(rsp.last_of_run));
                    n_checked++;
                    if (e.status == ST_FULL) n_full++;
                    if (e.status == ST_NOT_FOUND) n_miss++;
                    if (e.status == ST_EMPTY) n_empty++;
                end
            end
            if (req.valid && req.ready) begin
                apply_request(req.opcode, data_t'(req.value));
            end
            fail_count    <= fails;
            pending       <= expected_q.size();
            checked       <= n_checked;
            refused_full  <= n_full;
            remove_misses <= n_miss;
            empty_dumps   <= n_empty;
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: clock, reset and stimulus for the bounded deque, with random stalls
// on both channels; verdict taken from bdq_deque_checker
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_deque_checker and the block

module tb_top
    import bdq_pkg::*;
();

    localparam opcode_t OP_FIRST_UNUSED = 3'd5;
    localparam opcode_t OP_LAST_UNUSED  = 3'd7;
    localparam data_t   VAL_MIN         = 32'h8000_0000;
    localparam data_t   VAL_MAX         = 32'h7fff_ffff;
    localparam int      IDLE_LIMIT      = 4000;
    localparam int      HOLD_CYCLES     = 150;
    localparam int      TARGET_ITEMS    = 430;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int refused_full;
    int remove_misses;
    int empty_dumps;

    bit    tx_burst = 1'b0;
    bit    rx_burst = 1'b0;
    bit    hold_req = 1'b0;
    int    sent = 0;
    int    unused_sent = 0;
    int    idle_cycles = 0;
    data_t pool [$];

    bounded_deque_with_value_removal_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bdq_deque_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .refused_full  (refused_full),
        .remove_misses (remove_misses),
        .empty_dumps   (empty_dumps)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // values pushed recently, so removes can hit live entries
    function automatic data_t pool_pick();
        if (pool.size() == 0) begin
            return data_t'($urandom);
        end
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            1: return data_t'($urandom_range(0, 6)) - data_t'(3);
            2: return pool_pick();
            default: return data_t'($urandom);
        endcase
    endfunction

    task automatic send(input opcode_t op, input data_t val);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.opcode <= op;
        req_ch.value  <= val;
        req_ch.valid  <= 1'b1;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        sent++;
        if (op > OP_DUMP_REV) begin
            unused_sent++;
        end
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            pool.push_back(val);
            if (pool.size() > 24) void'(pool.pop_front());
        end
    endtask

    // called right after a transfer edge, so pending is read only after the next edge
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int      mode;
        int      len;
        int      round;
        int      r;
        int      push_cut;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.opcode <= OP_PUSH_FRONT;
        req_ch.value  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store corners
        send(OP_REMOVE, 32'd5);
        send(OP_DUMP_FWD, '0);
        send(OP_DUMP_REV, VAL_MAX);
        // removing the only entry
        send(OP_PUSH_FRONT, VAL_MAX);
        send(OP_REMOVE, VAL_MAX);
        send(OP_PUSH_BACK, VAL_MIN);
        send(OP_PUSH_FRONT, '1);
        send(OP_PUSH_BACK, '0);
        send(OP_REMOVE, 32'd12345);
        for (int u = OP_FIRST_UNUSED; u <= OP_LAST_UNUSED; u++) begin
            send(opcode_t'(u), data_t'($urandom));
        end
        send(OP_REMOVE, '1);
        // fill up, with a repeated value to test first-match removal
        for (int k = 0; k < DEPTH - 2; k++) begin
            send(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                 (k % 4 == 0) ? 32'd7 : data_t'($urandom));
        end
        send(OP_PUSH_FRONT, 32'd1);
        send(OP_PUSH_BACK, 32'd2);
        send(OP_DUMP_FWD, '0);
        send(OP_REMOVE, 32'd7);
        send(OP_DUMP_REV, '0);

        // random rounds: grow, shrink, mixed
        round = 0;
        while (sent < TARGET_ITEMS) begin
            mode = round % 3;
            len = $urandom_range(15, 35);
            tx_burst = ($urandom_range(0, 3) == 0);
            if (round == 2) begin
                // keep offering while the receiver holds off
                hold_req = 1'b1;
                tx_burst = 1'b1;
            end
            push_cut = (mode == 0) ? 14 : (mode == 1) ? 4 : 8;
            for (int k = 0; k < len && sent < TARGET_ITEMS; k++) begin
                r = $urandom_range(0, 19);
                if (r < push_cut) begin
                    send($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
                end else if (r < 16) begin
                    send(OP_REMOVE, ($urandom_range(0, 3) != 0) ? pool_pick() : pick_value());
                end else if (r < 19) begin
                    send($urandom_range(0, 1) ? OP_DUMP_REV : OP_DUMP_FWD, pick_value());
                end else begin
                    send(opcode_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                         pick_value());
                end
            end
            if (round % 4 == 3) begin
                drain();
            end
            round++;
        end

        drain();
        repeat (30) @(posedge clk);
        $display("run: %0d requests taken (%0d with unused opcodes), %0d results checked",
                 sent, unused_sent, checked);
        $display("corners: %0d pushes refused while full, %0d removes without match,",
                 refused_full, remove_misses);
        $display("         %0d empty dumps", empty_dumps);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result side: random stalls, stretches without stalls, one long hold-off
    initial
    begin
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_burst = !rx_burst;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
